// ===== sv/bcts_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and the channel blend function for the bilinear
// color table sampler. No dependencies.
package bcts_pkg;

    // Table geometry and weight precision
    localparam int TABLE_SIDE_BITS = 8;
    localparam int WEIGHT_BITS     = 8;

    localparam int SIDE_W   = TABLE_SIDE_BITS;
    localparam int HALF_W   = TABLE_SIDE_BITS - 1;
    localparam int IDX_W    = 2 * TABLE_SIDE_BITS;
    localparam int BANK_AW  = 2 * HALF_W;
    localparam int Q16_W    = 17;
    localparam int PROD_W   = Q16_W + SIDE_W;
    localparam int FX_W     = 16 + SIDE_W;
    localparam int BLEND_W  = 8 + WEIGHT_BITS + 1;
    localparam int COLOR_W  = 24;

    localparam logic [SIDE_W-1:0]      SIDE_MAX    = {SIDE_W{1'b1}};
    localparam logic [Q16_W-1:0]       ONE_Q16     = 17'h10000;
    localparam logic [WEIGHT_BITS:0]   WEIGHT_FULL = {1'b1, {WEIGHT_BITS{1'b0}}};
    localparam logic [BLEND_W-1:0]     WEIGHT_HALF = BLEND_W'(1) << (WEIGHT_BITS - 1);

    // Operation codes carried on s_tuser
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    // Stream payload layout
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 24;
    localparam int TEMP_LSB  = 0;
    localparam int RAIN_LSB  = 17;
    localparam int IDX_LSB   = 34;
    localparam int COLOR_LSB = 50;

    // Coordinate stage output toward the table and sampling stage
    typedef struct packed {
        logic                 valid;
        logic                 op;
        logic [FX_W-1:0]      fx;
        logic [FX_W-1:0]      fy;
        logic [IDX_W-1:0]     idx;
        logic [COLOR_W-1:0]   color;
    } coord_t;

    // Sample control aligned with the registered table read
    typedef struct packed {
        logic                   valid;
        logic [WEIGHT_BITS-1:0] wx;
        logic [WEIGHT_BITS-1:0] wy;
        logic                   xpar;
        logic                   ypar;
    } samp_t;

    typedef logic [1:0][1:0][COLOR_W-1:0] quad_t;

    // Rounded linear blend of two RGB colors, per 8-bit channel
    function automatic logic [COLOR_W-1:0] blend_rgb(
        input logic [COLOR_W-1:0]     a,
        input logic [COLOR_W-1:0]     b,
        input logic [WEIGHT_BITS-1:0] w
    );
        logic [WEIGHT_BITS:0]   wb;
        logic [WEIGHT_BITS:0]   wa;
        logic [BLEND_W-1:0]     acc;
        logic [COLOR_W-1:0]     res;
        wb  = {1'b0, w};
        wa  = WEIGHT_FULL - wb;
        res = '0;
        for (int ch = 0; ch < 3; ch++) begin
            acc = BLEND_W'(a[ch*8 +: 8]) * BLEND_W'(wa)
                + BLEND_W'(b[ch*8 +: 8]) * BLEND_W'(wb)
                + WEIGHT_HALF;
            res[ch*8 +: 8] = acc[WEIGHT_BITS +: 8];
        end
        return res;
    endfunction

endpackage

// ===== sv/bcts_coord.sv =====
`timescale 1ns / 1ps
// Coordinate front end: input saturation, rainfall scaling and the mapping
// onto fixed-point table coordinates. Two register stages. Uses bcts_pkg.
module bcts_coord (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               adv,
    input  logic                               accept,
    input  logic                               op,
    input  logic [bcts_pkg::Q16_W-1:0]         temperature,
    input  logic [bcts_pkg::Q16_W-1:0]         rainfall,
    input  logic [15:0]                        entry_index,
    input  logic [bcts_pkg::COLOR_W-1:0]       entry_color,
    output bcts_pkg::coord_t                   coord
);
    import bcts_pkg::*;

    logic [Q16_W-1:0]   t_sat;
    logic [Q16_W-1:0]   r_sat;
    logic [2*Q16_W-1:0] rt_prod;

    logic               v1_reg;
    logic               op1_reg;
    logic [Q16_W-1:0]   t1_reg;
    logic [Q16_W-1:0]   rp1_reg;
    logic [IDX_W-1:0]   idx1_reg;
    logic [COLOR_W-1:0] color1_reg;

    logic [PROD_W-1:0]  fx_prod;
    logic [PROD_W-1:0]  fy_prod;

    coord_t             c2_reg;

    // Stage 1: clamp to 1.0 and scale rainfall by temperature
    assign t_sat   = (temperature > ONE_Q16) ? ONE_Q16 : temperature;
    assign r_sat   = (rainfall > ONE_Q16) ? ONE_Q16 : rainfall;
    assign rt_prod = (2*Q16_W)'(t_sat) * (2*Q16_W)'(r_sat);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op1_reg    <= op;
            t1_reg     <= t_sat;
            rp1_reg    <= rt_prod[16 +: Q16_W];
            idx1_reg   <= IDX_W'(entry_index);
            color1_reg <= entry_color;
        end
    end

    // Stage 2: (1 - t) and (1 - r') times the top table coordinate
    assign fx_prod = PROD_W'(ONE_Q16 - t1_reg) * PROD_W'(SIDE_MAX);
    assign fy_prod = PROD_W'(ONE_Q16 - rp1_reg) * PROD_W'(SIDE_MAX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c2_reg <= '0;
        end
        else if (adv)
        begin
            c2_reg.valid <= v1_reg;
            c2_reg.op    <= op1_reg;
            c2_reg.fx    <= fx_prod[FX_W-1:0];
            c2_reg.fy    <= fy_prod[FX_W-1:0];
            c2_reg.idx   <= idx1_reg;
            c2_reg.color <= color1_reg;
        end
    end

    assign coord = c2_reg;

`ifndef SYNTH
    // The last column and row are only reached with a zero fraction, so the
    // wrapped second neighbor always carries zero weight.
    a_edge_x_zero_frac: assert property (@(posedge clk) disable iff (!rst_n)
        (c2_reg.valid && c2_reg.op == OP_LOOKUP && c2_reg.fx[16 +: SIDE_W] == SIDE_MAX)
        |-> (c2_reg.fx[15:0] == 16'h0000))
        else $error("x0 at table edge with nonzero fraction");
    a_edge_y_zero_frac: assert property (@(posedge clk) disable iff (!rst_n)
        (c2_reg.valid && c2_reg.op == OP_LOOKUP && c2_reg.fy[16 +: SIDE_W] == SIDE_MAX)
        |-> (c2_reg.fy[15:0] == 16'h0000))
        else $error("y0 at table edge with nonzero fraction");
`endif

endmodule

// ===== sv/bcts_table.sv =====
`timescale 1ns / 1ps
// Color table split into four banks by row and column parity, so the four
// neighbors of a sample are read together. Uses bcts_pkg.
module bcts_table (
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [bcts_pkg::IDX_W-1:0]     wr_index,
    input  logic [bcts_pkg::COLOR_W-1:0]   wr_color,
    input  logic                           rd_en,
    input  logic [bcts_pkg::SIDE_W-1:0]    x0,
    input  logic [bcts_pkg::SIDE_W-1:0]    y0,
    output bcts_pkg::quad_t                rd_data
);
    import bcts_pkg::*;

    logic [SIDE_W-1:0] wr_row;
    logic [SIDE_W-1:0] wr_col;
    logic [BANK_AW-1:0] wr_addr;
    logic [HALF_W-1:0] x_half;
    logic [HALF_W-1:0] y_half;
    logic [1:0][HALF_W-1:0] col_half;
    logic [1:0][HALF_W-1:0] row_half;

    // Write address split: parity picks the bank, upper bits the entry
    assign wr_row  = wr_index[SIDE_W +: SIDE_W];
    assign wr_col  = wr_index[0 +: SIDE_W];
    assign wr_addr = {wr_row[SIDE_W-1:1], wr_col[SIDE_W-1:1]};

    // Neighbor columns x0 and x0+1: one even, one odd. Past the last column
    // the even half wraps; that neighbor then has zero weight.
    assign x_half      = x0[SIDE_W-1:1];
    assign y_half      = y0[SIDE_W-1:1];
    assign col_half[0] = x0[0] ? x_half + 1'b1 : x_half;
    assign col_half[1] = x_half;
    assign row_half[0] = y0[0] ? y_half + 1'b1 : y_half;
    assign row_half[1] = y_half;

    for (genvar gr = 0; gr < 2; gr++)
    begin : g_row
        for (genvar gc = 0; gc < 2; gc++)
        begin : g_col
            logic [COLOR_W-1:0] bank_mem [2**BANK_AW];
            logic [COLOR_W-1:0] rd_reg;

            always_ff @(posedge clk)
            begin
                if (wr_en && wr_row[0] == 1'(gr) && wr_col[0] == 1'(gc))
                begin
                    bank_mem[wr_addr] <= wr_color;
                end
            end

            always_ff @(posedge clk)
            begin
                if (rd_en)
                begin
                    rd_reg <= bank_mem[{row_half[gr], col_half[gc]}];
                end
            end

            assign rd_data[gr][gc] = rd_reg;
        end
    end

`ifndef SYNTH
    // Writes only happen on a pipeline advance, which also refreshes the read
    // registers; a stalled read would otherwise see a changed entry.
    a_write_on_advance: assert property (@(posedge clk) wr_en |-> rd_en)
        else $error("table write while pipeline stalled");
`endif

endmodule

// ===== sv/bcts_blend.sv =====
`timescale 1ns / 1ps
// Bilinear blend of the four bank outputs: horizontal pass, then vertical
// pass, one register stage each. Uses bcts_pkg.
module bcts_blend (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  bcts_pkg::samp_t                samp,
    input  bcts_pkg::quad_t                rd_data,
    output logic                           res_valid,
    output logic [bcts_pkg::COLOR_W-1:0]   res_rgb
);
    import bcts_pkg::*;

    logic [COLOR_W-1:0]     top_left;
    logic [COLOR_W-1:0]     top_right;
    logic [COLOR_W-1:0]     bot_left;
    logic [COLOR_W-1:0]     bot_right;

    logic                   v4_reg;
    logic [COLOR_W-1:0]     top4_reg;
    logic [COLOR_W-1:0]     bot4_reg;
    logic [WEIGHT_BITS-1:0] wy4_reg;

    logic                   v5_reg;
    logic [COLOR_W-1:0]     rgb5_reg;

    // Route banks to neighbor positions by the parity of x0 and y0
    assign top_left  = rd_data[samp.ypar][samp.xpar];
    assign top_right = rd_data[samp.ypar][~samp.xpar];
    assign bot_left  = rd_data[~samp.ypar][samp.xpar];
    assign bot_right = rd_data[~samp.ypar][~samp.xpar];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v4_reg <= samp.valid;
            v5_reg <= v4_reg;
        end
    end

    // Horizontal pass on both rows, then vertical pass
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            top4_reg <= blend_rgb(top_left, top_right, samp.wx);
            bot4_reg <= blend_rgb(bot_left, bot_right, samp.wx);
            wy4_reg  <= samp.wy;
            rgb5_reg <= blend_rgb(top4_reg, bot4_reg, wy4_reg);
        end
    end

    assign res_valid = v5_reg;
    assign res_rgb   = rgb5_reg;

endmodule

// ===== sv/bilinear_color_table_sampler_unit.sv =====
`timescale 1ns / 1ps
// Top level of the bilinear color table sampler: stream ports, pipeline
// control and output skid stage. Uses bcts_pkg, bcts_coord, bcts_table, bcts_blend.
//
// Usage:
//   s_* carries one item per transaction. s_tuser = operation: 1 writes
//   entry_color at entry_index (row * 256 + column) and gives no result;
//   0 looks up temperature/rainfall (Q1.16, above 1.0 saturates) and gives
//   one RGB result on m_*. Fill the whole table before the first lookup.
//   Throughput: one item per cycle, back to back, while the skid entry is free;
//   the four-bank table (split by row and column parity) serves all four
//   neighbors at once. Pipeline: two coordinate stages, table read, two
//   blend stages and the output register lie between s_* and m_*.
//   A write takes effect for every lookup accepted after it.
//   Stall: a two-entry output stage (output register plus skid) holds
//   results; s_tready drops only once the skid entry is occupied, and the
//   whole pipeline then freezes without loss until m_tready returns.
//   Reset: clears all valid bits; table contents are undefined until written.
module bilinear_color_table_sampler_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // temperature[16:0], rainfall[33:17], entry_index[49:34],
    // entry_color[73:50], zero[79:74]
    input  logic [bcts_pkg::S_TDATA_W-1:0]     s_tdata,
    // operation[0]
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // red[7:0], green[15:8], blue[23:16]
    output logic [bcts_pkg::M_TDATA_W-1:0]     m_tdata
);
    import bcts_pkg::*;

    logic               adv;
    logic               accept;
    coord_t             coord;
    logic [SIDE_W-1:0]  x0;
    logic [SIDE_W-1:0]  y0;
    logic               wr_en;
    samp_t              samp_reg;
    quad_t              rd_data;
    logic               res_valid;
    logic [COLOR_W-1:0] res_rgb;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [M_TDATA_W-1:0] out_data_next;
    logic                 skid_valid_reg;
    logic                 skid_valid_next;
    logic [M_TDATA_W-1:0] skid_data_reg;
    logic [M_TDATA_W-1:0] skid_data_next;
    logic [M_TDATA_W-1:0] res_data;

    // Pipeline moves whenever the skid entry is free
    assign adv      = !skid_valid_reg;
    assign s_tready = adv;
    assign accept   = s_tvalid && adv;

    bcts_coord u_coord (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .accept      (accept),
        .op          (s_tuser),
        .temperature (s_tdata[TEMP_LSB +: Q16_W]),
        .rainfall    (s_tdata[RAIN_LSB +: Q16_W]),
        .entry_index (s_tdata[IDX_LSB +: 16]),
        .entry_color (s_tdata[COLOR_LSB +: COLOR_W]),
        .coord       (coord)
    );

    // Integer coordinates of the sample and the table write enable
    assign x0    = coord.fx[16 +: SIDE_W];
    assign y0    = coord.fy[16 +: SIDE_W];
    assign wr_en = adv && coord.valid && coord.op == OP_WRITE;

    bcts_table u_table (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_index (coord.idx),
        .wr_color (coord.color),
        .rd_en    (adv),
        .x0       (x0),
        .y0       (y0),
        .rd_data  (rd_data)
    );

    // Sample control, aligned with the registered bank outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samp_reg <= '0;
        end
        else if (adv)
        begin
            samp_reg.valid <= coord.valid && coord.op == OP_LOOKUP;
            samp_reg.wx    <= coord.fx[16-WEIGHT_BITS +: WEIGHT_BITS];
            samp_reg.wy    <= coord.fy[16-WEIGHT_BITS +: WEIGHT_BITS];
            samp_reg.xpar  <= x0[0];
            samp_reg.ypar  <= y0[0];
        end
    end

    bcts_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .samp      (samp_reg),
        .rd_data   (rd_data),
        .res_valid (res_valid),
        .res_rgb   (res_rgb)
    );

    // Output stage: output register backed by one skid entry
    assign res_data = {res_rgb[7:0], res_rgb[15:8], res_rgb[23:16]};

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = res_valid && adv;
                out_data_next  = res_data;
            end
        end
        else if (res_valid && adv)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTH
    // The skid entry only fills behind a held output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");
    // A result arriving at a stalled output must be parked, not dropped
    a_result_parked: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && adv && out_valid_reg && !m_tready) |=> skid_valid_reg)
        else $error("result lost at stalled output");
`endif

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for bilinear_color_table_sampler_unit: fills the color
// table, then drives directed and random lookups and compares each RGB result
// with an in-order prediction. Depends on bcts_pkg and the sampler RTL.
module tb_top;
    import bcts_pkg::*;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;

    // Shadow copy of the table and the colors still owed by the block
    logic [COLOR_W-1:0]    color_table_model [0:(1 << IDX_W) - 1];
    rgb_t                  pending_colors[$];
    rgb_t                  owed_color;

    int                    error_count = 0;
    bit                    send_idle   = 1'b0;
    bit                    recv_idle   = 1'b0;
    bit                    hold_req    = 1'b0;
    int                    hold_cycles = 0;

    bilinear_color_table_sampler_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Run limit, well beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= 40)
            $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    endtask

    // Rounded two-point blend of one 8-bit channel, weight in 1/256 steps
    function automatic logic [7:0] mix_channel(input logic [7:0] a, input logic [7:0] b,
                                               input logic [7:0] w);
        int unsigned acc;
        acc = a * (256 - w) + b * w + 128;
        return 8'(acc >> 8);
    endfunction

    function automatic logic [23:0] mix_rgb(input logic [23:0] a, input logic [23:0] b,
                                            input logic [7:0] w);
        logic [23:0] res;
        for (int ch = 0; ch < 3; ch++)
            res[ch*8 +: 8] = mix_channel(a[ch*8 +: 8], b[ch*8 +: 8], w);
        return res;
    endfunction

    // Color expected for one lookup against the current shadow table
    function automatic rgb_t sample_color(input logic [16:0] temp_in, input logic [16:0] rain_in);
        logic [16:0] temp_s;
        logic [16:0] rain_s;
        logic [16:0] rain_p;
        logic [33:0] prod;
        logic [24:0] fx;
        logic [24:0] fy;
        logic [7:0]  x0;
        logic [7:0]  x1;
        logic [7:0]  y0;
        logic [7:0]  y1;
        logic [23:0] upper;
        logic [23:0] lower;
        logic [23:0] mixed;
        rgb_t        res;
        temp_s = (temp_in > ONE_Q16) ? ONE_Q16 : temp_in;
        rain_s = (rain_in > ONE_Q16) ? ONE_Q16 : rain_in;
        prod   = 34'(rain_s) * 34'(temp_s);
        rain_p = prod[32:16];
        fx     = 25'(ONE_Q16 - temp_s) * 25'(SIDE_MAX);
        fy     = 25'(ONE_Q16 - rain_p) * 25'(SIDE_MAX);
        x0     = (fx[24:16] > 9'(SIDE_MAX)) ? SIDE_MAX : fx[23:16];
        y0     = (fy[24:16] > 9'(SIDE_MAX)) ? SIDE_MAX : fy[23:16];
        // neighbors held at the table edge
        x1     = (x0 == SIDE_MAX) ? x0 : x0 + 8'd1;
        y1     = (y0 == SIDE_MAX) ? y0 : y0 + 8'd1;
        upper  = mix_rgb(color_table_model[{y0, x0}], color_table_model[{y0, x1}], fx[15:8]);
        lower  = mix_rgb(color_table_model[{y1, x0}], color_table_model[{y1, x1}], fx[15:8]);
        mixed  = mix_rgb(upper, lower, fy[15:8]);
        res.red   = mixed[23:16];
        res.green = mixed[15:8];
        res.blue  = mixed[7:0];
        return res;
    endfunction

    // Offer one item, after a random gap when send_idle is set; update the shadow state on acceptance
    task automatic send_item(input logic op, input logic [16:0] temp, input logic [16:0] rain,
                             input logic [15:0] idx, input logic [23:0] color);
        logic [S_TDATA_W-1:0] word;
        int                   gap;
        word                     = '0;
        word[TEMP_LSB +: 17]     = temp;
        word[RAIN_LSB +: 17]     = rain;
        word[IDX_LSB +: 16]      = idx;
        word[COLOR_LSB +: 24]    = color;
        gap = send_idle ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= word;
        do @(posedge clk); while (!s_tready);
        if (op == OP_WRITE)
            color_table_model[idx] = color;
        else
            pending_colors.push_back(sample_color(temp, rain));
    endtask

    // Fields that an operation ignores carry random values
    task automatic send_lookup(input logic [16:0] temp, input logic [16:0] rain);
        send_item(OP_LOOKUP, temp, rain, 16'($urandom), 24'($urandom));
    endtask

    task automatic send_write(input logic [15:0] idx, input logic [23:0] color);
        send_item(OP_WRITE, 17'($urandom), 17'($urandom), idx, color);
    endtask

    function automatic logic [16:0] rand_q16();
        case ($urandom_range(0, 9))
            0:       return 17'd0;
            1:       return ONE_Q16;
            2:       return 17'($urandom_range(65537, 131071));
            3:       return 17'($urandom);
            4:       return 17'($urandom_range(0, 255));
            5:       return 17'($urandom_range(65280, 65536));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    // Every entry is written once before the first lookup
    task automatic test_table_fill();
        send_idle = 1'b0;
        for (int i = 0; i < (1 << IDX_W); i++)
            send_write(16'(i), 24'($urandom));
    endtask

    // Corners, held edges, saturation, midpoint and near-full weights
    task automatic test_edge_lookups();
        send_idle = 1'b1;
        recv_idle = 1'b1;
        send_write({8'd0,   8'd0},   24'hFFFFFF);
        send_write({8'd0,   8'd1},   24'h000000);
        send_write({8'd1,   8'd0},   24'h000000);
        send_write({8'd1,   8'd1},   24'hFFFFFF);
        send_write({8'd255, 8'd255}, 24'hFF00FF);
        send_write({8'd127, 8'd127}, 24'h000000);
        send_write({8'd127, 8'd128}, 24'hFFFFFF);
        send_write({8'd128, 8'd127}, 24'hFFFFFF);
        send_write({8'd128, 8'd128}, 24'h000000);
        send_lookup(ONE_Q16, ONE_Q16);
        send_lookup(17'h1FFFF, 17'h1FFFF);
        send_lookup(ONE_Q16, 17'd0);
        send_lookup(17'd0, ONE_Q16);
        send_lookup(17'd0, 17'd0);
        send_lookup(17'd32768, ONE_Q16);
        send_lookup(17'd32768, 17'h1FFFF);
        send_lookup(17'd65279, ONE_Q16);
    endtask

    // A write is seen by the lookup right behind it
    task automatic test_write_then_lookup();
        send_idle = 1'b0;
        send_write({8'd0, 8'd0}, 24'h123456);
        send_lookup(ONE_Q16, ONE_Q16);
        send_write({8'd0, 8'd0}, 24'hFFFFFF);
        send_lookup(ONE_Q16, ONE_Q16);
    endtask

    // Mostly lookups, some rewrites, idling switched in stretches
    task automatic test_random_traffic(input int count);
        logic [23:0] color;
        for (int i = 0; i < count; i++)
        begin
            if (i % 150 == 0)
            begin
                send_idle = ($urandom_range(0, 3) != 0);
                recv_idle = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 3) == 0)
            begin
                case ($urandom_range(0, 5))
                    0:       color = 24'h000000;
                    1:       color = 24'hFFFFFF;
                    default: color = 24'($urandom);
                endcase
                send_write(16'($urandom), color);
            end
            else
                send_lookup(rand_q16(), rand_q16());
        end
    endtask

    // Receiver stops for a long stretch while lookups keep coming back to back
    task automatic test_output_backpressure();
        send_idle   = 1'b0;
        hold_cycles = 400;
        hold_req    = 1'b1;
        for (int i = 0; i < 60; i++)
            send_lookup(rand_q16(), rand_q16());
    endtask

    // Result side: random ready gaps, plus the long hold when requested
    initial
    begin
        int gap;
        m_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                gap      = hold_cycles;
                hold_req = 1'b0;
            end
            else
                gap = recv_idle ? $urandom_range(0, 11) : 0;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (m_tvalid !== 1'b1);
        end
    end

    // Compare each result transaction with the oldest owed color
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_colors.size() == 0)
                report_mismatch("unexpected result", int'(m_tdata), 0);
            else
            begin
                owed_color = pending_colors.pop_front();
                if (m_tdata[7:0] !== owed_color.red)
                    report_mismatch("red", int'(m_tdata[7:0]), int'(owed_color.red));
                if (m_tdata[15:8] !== owed_color.green)
                    report_mismatch("green", int'(m_tdata[15:8]), int'(owed_color.green));
                if (m_tdata[23:16] !== owed_color.blue)
                    report_mismatch("blue", int'(m_tdata[23:16]), int'(owed_color.blue));
            end
        end
    end

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= OP_LOOKUP;
        s_tdata  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_table_fill();
        test_edge_lookups();
        test_write_then_lookup();
        test_random_traffic(900);
        test_output_backpressure();
        test_random_traffic(900);
        s_tvalid <= 1'b0;
        // drain, then allow for the pipeline depth
        wait (pending_colors.size() == 0);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/bcts_pkg.sv
sv/bcts_coord.sv
sv/bcts_table.sv
sv/bcts_blend.sv
sv/bilinear_color_table_sampler_unit.sv
dv/tb_top.sv
